[src/dtd_pkg.sv]
// Shared types and constants of the disparity-to-depth nearest tracker.
package dtd_pkg;

  // Register indexes of the configuration port
  localparam logic REG_NUMERATOR = 1'b0;
  localparam logic REG_INIT_MIN  = 1'b1;

  // Reset value of the starting minimum depth
  localparam logic [7:0] INIT_MIN_RESET = 8'd205;

  // Entries in the queue between front and back
  localparam int QDEPTH = 2;

  // Pixel as classified by the front
  typedef struct packed {
    logic [7:0]  disp;
    logic [9:0]  row;
    logic [10:0] col;
    logic        frame_start;
    logic        frame_end;
    logic        zero;   // disparity is zero: depth 0
    logic        sat;    // quotient is 256 or more: depth 255
    logic        track;  // position lies inside the tracked area
  } item_t;

  // Sequencer of the back
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } back_state_t;

endpackage

[src/disparity_to_depth_nearest_tracker.sv]
// Top level: configuration registers, front, queue and back of the depth tracker.
//
// Each pixel beat carries an 8-bit disparity with its row and column; each gives one
// result beat with depth = round(depth_numerator / (256 * disparity)), ties to even,
// saturated at 255, and 0 for zero disparity. The beat marked tlast also carries the
// frame summary: the smallest tracked depth at or below initial_min_depth and the box
// of pixels at that depth. A pixel with nonzero disparity whose quotient fits in 8
// bits passes through load, 8 steps of the one-bit-a-cycle divider and finish in the
// back; a zero or saturating disparity goes from load straight to finish. The front
// and a 2-entry queue take further pixels while the divider works; a stalled result
// holds off the input only once four more pixels are waiting behind it (one in the
// back, two queued, one in the front).
module disparity_to_depth_nearest_tracker #(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // disparity[7:0], row[17:8], column[28:18], zeros
  input  logic        in_tuser,   // frame_start
  input  logic        in_tlast,   // frame_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // depth[7:0], nearest_depth[15:8], near_first_row[25:16],
                                  // near_left_column[36:26], near_last_row[46:37],
                                  // near_right_column[57:47], zeros
  output logic        out_tlast   // frame_done
);
  import dtd_pkg::*;

  logic [31:0] num_r;
  logic [7:0]  init_min_r;
  logic        q_full;
  logic        q_empty;
  logic        push;
  logic        pop;
  item_t       push_item;
  item_t       pop_item;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r      <= '0;
      init_min_r <= INIT_MIN_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_NUMERATOR: num_r      <= cfg_wdata;
        REG_INIT_MIN:  init_min_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  dtd_front #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .numerator (num_r),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  dtd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  dtd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (!q_empty),
    .q_item     (pop_item),
    .pop        (pop),
    .numerator  (num_r),
    .init_min   (init_min_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

[src/dtd_front.sv]
// Front: takes pixel beats, classifies them and hands them to the queue.
module dtd_front #(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 2048
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [31:0]    in_tdata,   // disparity[7:0], row[17:8], column[28:18], zeros
  input  logic           in_tuser,   // frame_start
  input  logic           in_tlast,   // frame_end
  input  logic [31:0]    numerator,
  input  logic           q_full,
  output logic           push,
  output dtd_pkg::item_t push_item
);
  import dtd_pkg::*;

  logic  valid_r;
  item_t item_r;
  item_t item_nxt;
  logic  take;

  assign push      = valid_r && !q_full;
  assign in_tready = !valid_r || !q_full;
  assign take      = in_tvalid && in_tready;
  assign push_item = item_r;

  // Classify the incoming pixel
  always_comb begin
    item_nxt.disp        = in_tdata[7:0];
    item_nxt.row         = in_tdata[17:8];
    item_nxt.col         = in_tdata[28:18];
    item_nxt.frame_start = in_tuser;
    item_nxt.frame_end   = in_tlast;
    item_nxt.zero        = (in_tdata[7:0] == 8'd0);
    // q >= 256 exactly when numerator >= disparity << 16
    item_nxt.sat         = (in_tdata[7:0] != 8'd0) &&
                           (numerator[31:16] >= {8'd0, in_tdata[7:0]});
    item_nxt.track       = (32'(in_tdata[17:8]) < 32'(MAX_ROWS)) &&
                           (32'(in_tdata[28:18]) < 32'(MAX_COLS));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (push) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_nxt;
    end
  end

endmodule

[src/dtd_queue.sv]
// Short queue of classified pixels between front and back.
module dtd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dtd_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output dtd_pkg::item_t pop_item,
  output logic           empty
);
  import dtd_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  item_t             entry_r [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;

  assign full     = (count_r == CNT_W'(QDEPTH));
  assign empty    = (count_r == '0);
  assign pop_item = entry_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[src/dtd_back.sv]
// Back: bit-serial rounding divider, nearest-depth tracker and result register.
module dtd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  dtd_pkg::item_t q_item,
  output logic           pop,
  input  logic [31:0]    numerator,
  input  logic [7:0]     init_min,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [63:0]    out_tdata,
  output logic           out_tlast
);
  import dtd_pkg::*;

  back_state_t state_r, state_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  item_t       item_r, item_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [7:0]  quo_r, quo_nxt;

  // Tracker state
  logic [7:0]  min_r, min_nxt;
  logic [9:0]  fr_r, fr_nxt;
  logic [10:0] lc_r, lc_nxt;
  logic [9:0]  lr_r, lr_nxt;
  logic [10:0] rc_r, rc_nxt;

  // Result register
  logic        out_valid_r, out_valid_nxt;
  logic        out_last_r, out_last_nxt;
  logic [63:0] out_data_r, out_data_nxt;

  logic [15:0] den;
  logic [7:0]  num_lo;
  logic [16:0] rs;
  logic [16:0] diff;
  logic        ge;
  logic [16:0] rem2;
  logic        round_up;
  logic [8:0]  q_rnd;
  logic [7:0]  depth;
  logic        out_free;
  logic        trk;
  logic [7:0]  b_min;
  logic [9:0]  b_fr;
  logic [10:0] b_lc;
  logic [9:0]  b_lr;
  logic [10:0] b_rc;

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  // One restoring division step per cycle
  assign den    = {item_r.disp, 8'd0};
  assign num_lo = numerator[7:0];
  assign rs     = {rem_r, num_lo[cnt_r]};
  assign diff   = rs - {1'b0, den};
  assign ge     = (rs >= {1'b0, den});

  // Round to nearest, ties to even, then saturate
  assign rem2     = {rem_r, 1'b0};
  assign round_up = (rem2 > {1'b0, den}) || ((rem2 == {1'b0, den}) && quo_r[0]);
  assign q_rnd    = {1'b0, quo_r} + {8'd0, round_up};

  always_comb begin
    if (item_r.zero) begin
      depth = 8'd0;
    end else if (item_r.sat || q_rnd[8]) begin
      depth = 8'hFF;
    end else begin
      depth = q_rnd[7:0];
    end
  end

  // Tracker base: frame start reloads the threshold and clears the box
  always_comb begin
    if (item_r.frame_start) begin
      b_min = init_min;
      b_fr  = '0;
      b_lc  = '0;
      b_lr  = '0;
      b_rc  = '0;
    end else begin
      b_min = min_r;
      b_fr  = fr_r;
      b_lc  = lc_r;
      b_lr  = lr_r;
      b_rc  = rc_r;
    end
  end

  assign trk = (depth != 8'd0) && item_r.track;

  // Sequencer, tracker update and result load
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    item_nxt      = item_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    min_nxt       = min_r;
    fr_nxt        = fr_r;
    lc_nxt        = lc_r;
    lr_nxt        = lr_r;
    rc_nxt        = rc_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_last_nxt  = out_last_r;
    out_data_nxt  = out_data_r;
    pop           = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          pop      = 1'b1;
          item_nxt = q_item;
          rem_nxt  = numerator[23:8];
          quo_nxt  = '0;
          cnt_nxt  = 3'd7;
          state_nxt = (q_item.zero || q_item.sat) ? ST_FIN : ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = ge ? diff[15:0] : rs[15:0];
        quo_nxt = {quo_r[6:0], ge};
        cnt_nxt = cnt_r - 3'd1;
        if (cnt_r == 3'd0) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          min_nxt = b_min;
          fr_nxt  = b_fr;
          lc_nxt  = b_lc;
          lr_nxt  = b_lr;
          rc_nxt  = b_rc;
          if (trk && (depth < b_min)) begin
            min_nxt = depth;
            fr_nxt  = item_r.row;
            lc_nxt  = item_r.col;
            lr_nxt  = item_r.row;
            rc_nxt  = item_r.col;
          end else if (trk && (depth == b_min)) begin
            lc_nxt = (item_r.col < b_lc) ? item_r.col : b_lc;
            rc_nxt = (item_r.col > b_rc) ? item_r.col : b_rc;
            lr_nxt = item_r.row;
          end
          out_valid_nxt = 1'b1;
          out_last_nxt  = item_r.frame_end;
          if (item_r.frame_end) begin
            out_data_nxt = {6'd0, rc_nxt, lr_nxt, lc_nxt, fr_nxt, min_nxt, depth};
          end else begin
            out_data_nxt = {56'd0, depth};
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and tracker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      min_r       <= INIT_MIN_RESET;
      fr_r        <= '0;
      lc_r        <= '0;
      lr_r        <= '0;
      rc_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      min_r       <= min_nxt;
      fr_r        <= fr_nxt;
      lc_r        <= lc_nxt;
      lr_r        <= lr_nxt;
      rc_r        <= rc_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    out_last_r <= out_last_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTH
  // Box columns stay ordered
  a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
    lc_r <= rc_r)
    else $error("nearest box left column past right column");

  // Divider counts down one step a cycle
  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && cnt_r != 3'd0) |=>
      (state_r == ST_DIV && cnt_r == $past(cnt_r) - 3'd1))
    else $error("divider step count broken");

  // Summary fields are zero on beats that do not close a frame
  a_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (out_data_r[63:8] == 56'd0))
    else $error("summary fields set on non-final beat");

  // A finished pixel waits for the result register without losing its data
  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && !out_free) |=> (state_r == ST_FIN && $stable(quo_r)))
    else $error("finished pixel lost while result stalled");
`endif

endmodule

[sim/testbench.sv]
// Self-checking testbench of the disparity-to-depth nearest tracker: directed and random frames.
`timescale 1ns / 1ps

module testbench;
  import dtd_pkg::*;

  localparam int MAX_ROWS      = 1024;
  localparam int MAX_COLS      = 2048;
  localparam int SETTLE_CYCLES = 20;   // longest latency with margin
  localparam int HOLD_CYCLES   = 300;

  typedef enum int {
    FRAME_NORMAL,
    FRAME_NO_START,
    FRAME_NO_END,
    FRAME_EXTRA_START
  } frame_kind_t;

  // One depth result as the block should give it
  typedef struct {
    logic [7:0]  depth;
    logic        frame_done;
    logic [7:0]  nearest;
    logic [9:0]  first_row;
    logic [10:0] left_col;
    logic [9:0]  last_row;
    logic [10:0] right_col;
  } depth_result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_addr;
  logic [31:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic        out_tlast;

  // Register copies and tracker state of the predictor
  logic [31:0] numerator;
  logic [7:0]  init_min;
  logic [7:0]  near_min;
  logic [9:0]  near_first_row;
  logic [10:0] near_left_col;
  logic [9:0]  near_last_row;
  logic [10:0] near_right_col;

  depth_result_t pending_results[$];

  int  failures        = 0;
  int  pixels_sent     = 0;
  int  results_checked = 0;
  int  summaries_seen  = 0;
  int  settings_used   = 0;
  int  hold_cycles     = 0;
  bit  idle_on         = 1'b1;

  disparity_to_depth_nearest_tracker #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Rounded quotient, ties to even, saturated at 255
  function automatic logic [7:0] depth_for(logic [7:0] disp);
    logic [63:0] den, quo, rem;
    if (disp == 8'd0) return 8'd0;
    den = 64'(disp) << 8;
    quo = 64'(numerator) / den;
    rem = 64'(numerator) % den;
    if ((2 * rem > den) || ((2 * rem == den) && quo[0])) quo++;
    return (quo > 64'd255) ? 8'd255 : quo[7:0];
  endfunction

  // Tracker update for one accepted pixel
  function automatic depth_result_t track_pixel(logic [7:0] disp, logic [9:0] row,
                                                logic [10:0] col, logic frame_start,
                                                logic frame_end);
    depth_result_t res;
    logic [7:0]    dep;
    if (frame_start) begin
      near_min       = init_min;
      near_first_row = '0;
      near_left_col  = '0;
      near_last_row  = '0;
      near_right_col = '0;
    end
    dep = depth_for(disp);
    if (dep != 0 && int'(row) < MAX_ROWS && int'(col) < MAX_COLS) begin
      if (dep < near_min) begin
        near_min       = dep;
        near_first_row = row;
        near_left_col  = col;
        near_last_row  = row;
        near_right_col = col;
      end else if (dep == near_min) begin
        if (near_left_col > col) near_left_col = col;
        if (near_right_col < col) near_right_col = col;
        near_last_row = row;
      end
    end
    res.depth      = dep;
    res.frame_done = frame_end;
    res.nearest    = frame_end ? near_min : '0;
    res.first_row  = frame_end ? near_first_row : '0;
    res.left_col   = frame_end ? near_left_col : '0;
    res.last_row   = frame_end ? near_last_row : '0;
    res.right_col  = frame_end ? near_right_col : '0;
    return res;
  endfunction

  // Result checker
  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    depth_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no pixel outstanding: tdata %h", out_tdata);
        failures++;
      end else begin
        want = pending_results.pop_front();
        check_field("depth", int'(want.depth), int'(out_tdata[7:0]));
        check_field("frame_done", int'(want.frame_done), int'(out_tlast));
        check_field("nearest_depth", int'(want.nearest), int'(out_tdata[15:8]));
        check_field("near_first_row", int'(want.first_row), int'(out_tdata[25:16]));
        check_field("near_left_column", int'(want.left_col), int'(out_tdata[36:26]));
        check_field("near_last_row", int'(want.last_row), int'(out_tdata[46:37]));
        check_field("near_right_column", int'(want.right_col), int'(out_tdata[57:47]));
        results_checked++;
        if (out_tlast) summaries_seen++;
      end
    end
  end

  // Result side: random stalls and a long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 7) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Send one pixel beat; tvalid stays high until the next beat or stop_sending
  task automatic send_pixel(logic [7:0] disp, logic [9:0] row, logic [10:0] col,
                            logic frame_start, logic frame_end);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, col, row, disp};
    in_tuser  <= frame_start;
    in_tlast  <= frame_end;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(track_pixel(disp, row, col, frame_start, frame_end));
    pixels_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // Sender pauses until every result is back and the block has settled
  task automatic wait_drained();
    stop_sending();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic addr, logic [31:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (addr == REG_NUMERATOR) numerator = data;
    else init_min = data[7:0];
  endtask

  task automatic set_regs(logic [31:0] num, logic [7:0] thr);
    wait_drained();
    write_reg(REG_NUMERATOR, num);
    write_reg(REG_INIT_MIN, {24'd0, thr});
    settings_used++;
  endtask

  // Numerator that puts depths of mid-range disparities well inside 1..255
  function automatic logic [31:0] mid_numerator();
    return 256 * $urandom_range(1, 60) * $urandom_range(2, 40) + $urandom_range(0, 511);
  endfunction

  function automatic frame_kind_t pick_frame_kind();
    case ($urandom_range(0, 9))
      0:       return FRAME_NO_START;
      1:       return FRAME_NO_END;
      2:       return FRAME_EXTRA_START;
      default: return FRAME_NORMAL;
    endcase
  endfunction

  // Raster-order frame; disparities cluster so that ties at the minimum occur
  task automatic send_frame(frame_kind_t kind);
    int rows, cols, row0, col0, cluster, mid_pix, idx;
    logic [7:0] disp;
    rows    = $urandom_range(1, 4);
    cols    = $urandom_range(2, 16);
    row0    = $urandom_range(0, MAX_ROWS - rows);
    col0    = $urandom_range(0, MAX_COLS - cols);
    cluster = $urandom_range(1, 255);
    mid_pix = $urandom_range(1, rows * cols - 1);
    idx     = 0;
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        case ($urandom_range(0, 9))
          0:       disp = 8'd0;
          1, 2, 3: disp = 8'($urandom_range(1, 255));
          default: disp = (cluster == 255) ? 8'd255
                                           : 8'(cluster + $urandom_range(0, 1));
        endcase
        send_pixel(disp, 10'(row0 + r), 11'(col0 + c),
                   (idx == 0 && kind != FRAME_NO_START) ||
                   (idx == mid_pix && kind == FRAME_EXTRA_START),
                   (idx == rows * cols - 1) && kind != FRAME_NO_END);
        idx++;
      end
    end
  endtask

  task automatic send_random_frames(int count);
    int target;
    target = pixels_sent + count;
    while (pixels_sent < target) send_frame(pick_frame_kind());
  endtask

  // Reset values: zero numerator gives zero depth, threshold 205 and an empty box
  task automatic test_reset_state();
    send_pixel(8'd0, 10'd0, 11'd0, 1'b1, 1'b0);
    send_pixel(8'd255, 10'd0, 11'd1, 1'b0, 1'b0);
    send_pixel(8'd1, 10'd1, 11'd0, 1'b0, 1'b0);
    send_pixel(8'd128, 10'd1, 11'd1, 1'b0, 1'b1);
  endtask

  // Ties to even, quotients rounding to zero, extremes of row and column
  task automatic test_rounding();
    set_regs(32'd384, 8'd255);
    send_pixel(8'd1, 10'd0, 11'd0, 1'b1, 1'b0);       // 1.5 -> 2
    send_pixel(8'd3, 10'd0, 11'd2047, 1'b0, 1'b0);    // 0.5 -> 0, not tracked
    send_pixel(8'd2, 10'd1023, 11'd0, 1'b0, 1'b0);    // 0.75 -> 1
    send_pixel(8'd255, 10'd1023, 11'd2047, 1'b0, 1'b1);
    set_regs(32'd640, 8'd255);
    send_pixel(8'd1, 10'd5, 11'd7, 1'b1, 1'b0);       // 2.5 -> 2
    send_pixel(8'd2, 10'd5, 11'd8, 1'b0, 1'b0);       // 1.25 -> 1
    send_pixel(8'd4, 10'd6, 11'd3, 1'b0, 1'b1);       // 0.625 -> 1, box grows
  endtask

  // Saturation at 255, equal to the threshold, so the box grows from zero
  task automatic test_saturation();
    set_regs(32'hFFFF_FFFF, 8'd255);
    send_pixel(8'd1, 10'd3, 11'd9, 1'b1, 1'b0);
    send_pixel(8'd255, 10'd4, 11'd1, 1'b0, 1'b0);
    send_pixel(8'd0, 10'd4, 11'd2, 1'b0, 1'b0);
    send_pixel(8'd200, 10'd1023, 11'd2047, 1'b0, 1'b1);
  endtask

  // Threshold zero tracks nothing; a depth equal to the threshold extends the box
  task automatic test_threshold_equal();
    set_regs(32'd2560, 8'd0);
    send_pixel(8'd1, 10'd2, 11'd2, 1'b1, 1'b0);
    send_pixel(8'd2, 10'd2, 11'd3, 1'b0, 1'b1);
    set_regs(32'd2560, 8'd10);
    send_pixel(8'd1, 10'd8, 11'd20, 1'b1, 1'b0);      // 10 == threshold
    send_pixel(8'd2, 10'd9, 11'd30, 1'b0, 1'b0);      // 5, new box
    send_pixel(8'd2, 10'd9, 11'd31, 1'b0, 1'b1);
  endtask

  // No frame start: tracking carries on; a new threshold waits for the next start
  task automatic test_missing_start();
    set_regs(32'd2560, 8'd50);
    send_pixel(8'd1, 10'd1, 11'd1, 1'b1, 1'b1);
    send_pixel(8'd2, 10'd2, 11'd4, 1'b0, 1'b1);
    set_regs(32'd2560, 8'd3);
    send_pixel(8'd4, 10'd3, 11'd5, 1'b0, 1'b0);       // 2.5 -> 2, old threshold kept
    send_pixel(8'd3, 10'd4, 11'd6, 1'b1, 1'b1);       // start mid-frame, 3 == threshold
  endtask

  // Random frames over a sweep of register settings
  task automatic test_config_sweep();
    for (int s = 0; s < 7; s++) begin
      case (s)
        0: set_regs(32'd0, 8'($urandom_range(0, 255)));
        1: set_regs(32'hFFFF_FFFF, 8'd255);
        2: set_regs(32'hFFFF_FFFF, 8'd0);
        3: set_regs(mid_numerator(), 8'd255);
        4: set_regs(mid_numerator(), 8'($urandom_range(0, 255)));
        5: set_regs(mid_numerator(), INIT_MIN_RESET);
        default: set_regs($urandom, 8'($urandom_range(0, 255)));
      endcase
      idle_on = (s != 3);
      send_random_frames((s == 0 || s == 2) ? 60 : (s == 1 || s == 6) ? 150 : 200);
    end
    idle_on = 1'b1;
  endtask

  // Result side held off while pixels keep coming, so the input stalls
  task automatic test_backpressure();
    set_regs(mid_numerator(), 8'($urandom_range(100, 255)));
    @(posedge clk);
    hold_cycles = HOLD_CYCLES;
    send_random_frames(120);
  endtask

  // Closing stretch at full rate on both sides
  task automatic test_full_rate();
    set_regs(mid_numerator(), 8'($urandom_range(0, 255)));
    idle_on = 1'b0;
    send_random_frames(300);
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = REG_NUMERATOR;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    in_tlast  = 1'b0;
    numerator      = '0;
    init_min       = INIT_MIN_RESET;
    near_min       = INIT_MIN_RESET;
    near_first_row = '0;
    near_left_col  = '0;
    near_last_row  = '0;
    near_right_col = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_rounding();
    test_saturation();
    test_threshold_equal();
    test_missing_start();
    test_config_sweep();
    test_backpressure();
    test_full_rate();
    wait_drained();

    $display("Covered %0d pixels, %0d results checked, %0d frame summaries, %0d settings",
             pixels_sent, results_checked, summaries_seen, settings_used);
    $display("Rounding ties, saturation, threshold ties, missing frame marks and stalls exercised");
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
src/dtd_pkg.sv
src/dtd_front.sv
src/dtd_queue.sv
src/dtd_back.sv
src/disparity_to_depth_nearest_tracker.sv
sim/testbench.sv
